/* design/windowed_rms_level_meter_core_assert.svh */
// Assertion macros for the RMS level meter core.
// Depends on signals named clk and rst in the including scope.
`ifndef WINDOWED_RMS_LEVEL_METER_CORE_ASSERT_SVH
`define WINDOWED_RMS_LEVEL_METER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define WRMS_CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high
`define WRMS_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wrms_pkg.sv */
// Constants and types for the windowed RMS level meter.
// No dependencies; used by every module of the block.
package wrms_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int WINDOW_BITS = 13;
  localparam int SUM_BITS    = 37;
  localparam int RAD_BITS    = SUM_BITS + 1;
  localparam int ROOT_BITS   = RAD_BITS / 2;
  localparam int SQREM_BITS  = ROOT_BITS + 3;
  localparam int MV_BITS     = 12;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;

  localparam logic [WINDOW_BITS-1:0] MAX_WINDOW   = 13'd4096;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 13'd2400;
  localparam logic [WINDOW_BITS-1:0] FULL_SCALE   = 13'd4095;
  localparam logic [MV_BITS-1:0]     MV_SCALE     = 12'd3300;

  // Millivolt scaling: root*3300/4095 equals root*220/273; multiply by
  // ceil(220 * 2^28 / 273) and drop 28 bits, exact for any 19-bit root
  localparam int                    RECIP_BITS = 28;
  localparam int                    MV_SHIFT   = 28;
  localparam logic [RECIP_BITS-1:0] MV_RECIP   = 28'd216321613;
  localparam int                    PROD_BITS  = ROOT_BITS + RECIP_BITS;

  // Level bar thresholds: sample/1000 at least 1, 2 and 3
  localparam logic [SAMPLE_BITS-1:0] BAR_STEP_1 = 12'd1000;
  localparam logic [SAMPLE_BITS-1:0] BAR_STEP_2 = 12'd2000;
  localparam logic [SAMPLE_BITS-1:0] BAR_STEP_3 = 12'd3000;

  // Serial unit step counts
  localparam int DIV_STEPS  = SUM_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  // Queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Register index decode
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic                   bar_red;
    logic                   bar_green;
    logic                   bar_blue;
    logic                   heartbeat;
    logic                   last;
    logic [SUM_BITS-1:0]    sum;
    logic [WINDOW_BITS-1:0] len;
  } queue_entry_t;

  typedef struct packed {
    logic                   start;
    logic [SUM_BITS-1:0]    dividend;
    logic [WINDOW_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/wrms_front.sv */
// Front end: accepts samples, drives the level bar and heartbeat, accumulates squares.
// Depends on wrms_pkg.
module wrms_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [wrms_pkg::WINDOW_BITS-1:0]    window_len,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wrms_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic                                q_full,
  output logic                                q_push,
  output wrms_pkg::queue_entry_t              q_entry
);

  logic [wrms_pkg::SUM_BITS-1:0]    square_sum;
  logic [wrms_pkg::WINDOW_BITS-1:0] window_count;
  logic                             beat;
  logic [wrms_pkg::SQ_BITS-1:0]     square;
  logic [wrms_pkg::SUM_BITS-1:0]    sum_next;
  logic [wrms_pkg::WINDOW_BITS-1:0] count_next;
  logic [wrms_pkg::WINDOW_BITS-1:0] len_eff;
  logic                             last;

  // Clamp the window length into 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      len_eff = wrms_pkg::WINDOW_BITS'(1);
    end else if (window_len > wrms_pkg::MAX_WINDOW) begin
      len_eff = wrms_pkg::MAX_WINDOW;
    end else begin
      len_eff = window_len;
    end
  end

  assign square     = {{wrms_pkg::SAMPLE_BITS{1'b0}}, sample}
                    * {{wrms_pkg::SAMPLE_BITS{1'b0}}, sample};
  assign sum_next   = square_sum
                    + {{(wrms_pkg::SUM_BITS - wrms_pkg::SQ_BITS){1'b0}}, square};
  assign count_next = window_count + wrms_pkg::WINDOW_BITS'(1);
  assign last       = (count_next >= len_eff);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the sample into one queue entry
  always_comb begin
    q_entry.bar_red   = (sample >= wrms_pkg::BAR_STEP_1);
    q_entry.bar_green = (sample >= wrms_pkg::BAR_STEP_2);
    q_entry.bar_blue  = (sample >= wrms_pkg::BAR_STEP_3);
    q_entry.heartbeat = ~beat;
    q_entry.last      = last;
    q_entry.sum       = sum_next;
    q_entry.len       = len_eff;
  end

  // Advance the window accumulator on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      window_count <= '0;
      beat         <= 1'b0;
    end else if (q_push) begin
      beat <= ~beat;
      if (last) begin
        square_sum   <= '0;
        window_count <= '0;
      end else begin
        square_sum   <= sum_next;
        window_count <= count_next;
      end
    end
  end

endmodule

/* design/wrms_queue.sv */
// Short queue of classified samples between the front and back ends.
// Depends on wrms_pkg.
module wrms_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  wrms_pkg::queue_entry_t      push_entry,
  input  logic                        pop,
  output wrms_pkg::queue_entry_t      head,
  output logic                        empty,
  output logic                        full,
  output logic [wrms_pkg::QUEUE_AW:0] level
);

  wrms_pkg::queue_entry_t             entries [wrms_pkg::QUEUE_DEPTH];
  logic [wrms_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [wrms_pkg::QUEUE_AW-1:0]      rd_ptr;

  assign empty = (level == '0);
  assign full  = (level == (wrms_pkg::QUEUE_AW+1)'(wrms_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wrms_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wrms_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        level <= level + (wrms_pkg::QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        level <= level - (wrms_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

/* design/wrms_divider.sv */
// Serial restoring divider, one quotient bit per cycle, used by the back end.
// Depends on wrms_pkg.
module wrms_divider (
  input  logic                clk,
  input  logic                rst,
  input  wrms_pkg::div_req_t  req,
  output wrms_pkg::div_rsp_t  rsp
);

  logic                               busy;
  logic                               done;
  logic [wrms_pkg::DIV_CNT_W-1:0]     step;
  logic [wrms_pkg::WINDOW_BITS-1:0]   rem;
  logic [wrms_pkg::WINDOW_BITS-1:0]   divisor;
  logic [wrms_pkg::SUM_BITS-1:0]      quo;
  logic [wrms_pkg::WINDOW_BITS:0]     trial;
  logic [wrms_pkg::WINDOW_BITS:0]     diff;
  logic                               fits;

  assign trial = {rem, quo[wrms_pkg::SUM_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // Control: start, count steps, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + wrms_pkg::DIV_CNT_W'(1);
        if (step == wrms_pkg::DIV_CNT_W'(wrms_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[wrms_pkg::WINDOW_BITS-1:0];
        quo <= {quo[wrms_pkg::SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[wrms_pkg::WINDOW_BITS-1:0];
        quo <= {quo[wrms_pkg::SUM_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/wrms_back.sv */
// Back end: drains the queue, works out RMS counts and millivolts, holds the result register.
// Depends on wrms_pkg and drives the wrms_divider.
module wrms_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  wrms_pkg::queue_entry_t           q_head,
  output logic                             q_pop,
  output wrms_pkg::div_req_t               div_req,
  input  wrms_pkg::div_rsp_t               div_rsp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             bar_red,
  output logic                             bar_green,
  output logic                             bar_blue,
  output logic                             heartbeat,
  output logic                             rms_valid,
  output logic [wrms_pkg::SAMPLE_BITS-1:0] rms_counts,
  output logic [wrms_pkg::MV_BITS-1:0]     rms_millivolts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIVA   = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]                           state;
  logic [2:0]                           state_next;
  logic                                 out_free;
  logic                                 load_plain;
  logic                                 load_rms;
  logic                                 hold_red;
  logic                                 hold_green;
  logic                                 hold_blue;
  logic                                 hold_beat;
  logic [wrms_pkg::RAD_BITS-1:0]        rad;
  logic [wrms_pkg::SQREM_BITS-1:0]      sq_rem;
  logic [wrms_pkg::ROOT_BITS-1:0]       root;
  logic [wrms_pkg::SQRT_CNT_W-1:0]      sq_step;
  logic [wrms_pkg::SQREM_BITS-1:0]      sq_shift;
  logic [wrms_pkg::SQREM_BITS-1:0]      sq_trial;
  logic                                 sq_fits;
  logic [wrms_pkg::PROD_BITS-1:0]       product;

  assign out_free   = !out_valid || !out_stall;
  assign load_plain = (state == ST_IDLE) && !q_empty && !q_head.last && out_free;
  assign load_rms   = (state == ST_DONE) && out_free;
  assign q_pop      = (state == ST_IDLE) && !q_empty && (q_head.last || out_free);

  // Square root step: bring down two radicand bits, try root*4+1
  assign sq_shift = {sq_rem[wrms_pkg::SQREM_BITS-3:0],
                     rad[wrms_pkg::RAD_BITS-1:wrms_pkg::RAD_BITS-2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_fits  = (sq_shift >= sq_trial);

  // Divider request: mean square of a closing window
  always_comb begin
    div_req.start    = (state == ST_IDLE) && !q_empty && q_head.last;
    div_req.dividend = q_head.sum;
    div_req.divisor  = q_head.len;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && q_head.last) begin
          state_next = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (div_rsp.done) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_step == wrms_pkg::SQRT_CNT_W'(wrms_pkg::SQRT_STEPS - 1)) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the bar and heartbeat of a window-closing sample while the maths runs
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && q_pop) begin
      hold_red   <= q_head.bar_red;
      hold_green <= q_head.bar_green;
      hold_blue  <= q_head.bar_blue;
      hold_beat  <= q_head.heartbeat;
    end
  end

  // Square root datapath and millivolt scaling product
  always_ff @(posedge clk) begin
    if ((state == ST_DIVA) && div_rsp.done) begin
      rad     <= {1'b0, div_rsp.quotient};
      sq_rem  <= '0;
      root    <= '0;
      sq_step <= '0;
    end else if (state == ST_ROOT) begin
      rad     <= {rad[wrms_pkg::RAD_BITS-3:0], 2'b00};
      sq_step <= sq_step + wrms_pkg::SQRT_CNT_W'(1);
      if (sq_fits) begin
        sq_rem <= sq_shift - sq_trial;
        root   <= {root[wrms_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        sq_rem <= sq_shift;
        root   <= {root[wrms_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
    if (state == ST_MULT) begin
      product <= {{wrms_pkg::RECIP_BITS{1'b0}}, root}
               * {{wrms_pkg::ROOT_BITS{1'b0}}, wrms_pkg::MV_RECIP};
    end
  end

  // Result register: load a plain result or a window result, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_plain || load_rms) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      bar_red        <= q_head.bar_red;
      bar_green      <= q_head.bar_green;
      bar_blue       <= q_head.bar_blue;
      heartbeat      <= q_head.heartbeat;
      rms_valid      <= 1'b0;
      rms_counts     <= '0;
      rms_millivolts <= '0;
    end else if (load_rms) begin
      bar_red        <= hold_red;
      bar_green      <= hold_green;
      bar_blue       <= hold_blue;
      heartbeat      <= hold_beat;
      rms_valid      <= 1'b1;
      rms_counts     <= root[wrms_pkg::SAMPLE_BITS-1:0];
      rms_millivolts <= product[wrms_pkg::MV_SHIFT+wrms_pkg::MV_BITS-1:wrms_pkg::MV_SHIFT];
    end
  end

endmodule

/* design/windowed_rms_level_meter_core.sv */
// Windowed RMS level meter: sample channel in, result channel out, APB-style register port.
// Depends on wrms_pkg, wrms_front, wrms_queue, wrms_divider, wrms_back and the assert header.
//
// Usage
//   Samples arrive on in_valid/in_stall/sample; a transfer happens when in_valid is high
//   and in_stall is low. Every sample yields exactly one result on out_valid/out_stall:
//   level bar, heartbeat, and on the sample that closes a window, rms_valid with the
//   RMS in counts and in millivolts (both zero otherwise).
//   window_len sits at byte address 0 and may be written only while the block is idle.
//   Sequence: a sample that does not close a window is written into the queue and then
//   loaded into the result register. A window-closing sample passes through the start of
//   the serial divider, 37 divider steps, a hand-off, 19 square root steps, a scaling
//   multiply and the result load.
//   Throughput: one sample per cycle while no window closes and out_stall stays low; a
//   window-closing sample holds the back end through its maths, during which the
//   four-entry queue takes further samples until it fills.
//   Reset: synchronous, active high; clears the sum, count, heartbeat, queue and out_valid,
//   and sets window_len to 2400.
//   A stalled result holds in the output register; the queue absorbs further samples,
//   and in_stall rises once it is full.
`include "windowed_rms_level_meter_core_assert.svh"

module windowed_rms_level_meter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wrms_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [wrms_pkg::DATA_BITS-1:0]   pwdata,
  output logic [wrms_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [wrms_pkg::SAMPLE_BITS-1:0] sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             bar_red,
  output logic                             bar_green,
  output logic                             bar_blue,
  output logic                             heartbeat,
  output logic                             rms_valid,
  output logic [wrms_pkg::SAMPLE_BITS-1:0] rms_counts,
  output logic [wrms_pkg::MV_BITS-1:0]     rms_millivolts
);

  logic [wrms_pkg::WINDOW_BITS-1:0] window_len;
  logic                             reg_hit;
  logic                             q_push;
  logic                             q_pop;
  logic                             q_empty;
  logic                             q_full;
  logic [wrms_pkg::QUEUE_AW:0]      q_level;
  wrms_pkg::queue_entry_t           q_in;
  wrms_pkg::queue_entry_t           q_head;
  wrms_pkg::div_req_t               div_req;
  wrms_pkg::div_rsp_t               div_rsp;

  // Register port: single window length register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[wrms_pkg::ADDR_BITS-1] == wrms_pkg::REG_WINDOW_LEN);
  assign prdata  = reg_hit
                 ? {{(wrms_pkg::DATA_BITS - wrms_pkg::WINDOW_BITS){1'b0}}, window_len}
                 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wrms_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      window_len <= pwdata[wrms_pkg::WINDOW_BITS-1:0];
    end
  end

  wrms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .window_len (window_len),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  wrms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full),
    .level      (q_level)
  );

  wrms_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wrms_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bar_red        (bar_red),
    .bar_green      (bar_green),
    .bar_blue       (bar_blue),
    .heartbeat      (heartbeat),
    .rms_valid      (rms_valid),
    .rms_counts     (rms_counts),
    .rms_millivolts (rms_millivolts)
  );

  // Checks
  `WRMS_CHK_IMPLY(a_rms_zero, out_valid && !rms_valid, (rms_counts == '0) && (rms_millivolts == '0), "RMS fields not zero on a plain result")
  `WRMS_CHK_IMPLY(a_no_pop_empty, q_level == '0, !q_pop, "pop from an empty queue")
  `WRMS_CHK_NEXT(a_level_up, q_push && !q_pop, q_level == ($past(q_level) + 3'd1), "queue level did not rise on push")

endmodule

/* sim/windowed_rms_level_meter_core_tb.sv */
// Testbench for windowed_rms_level_meter_core: drives samples and register writes, predicts
// bar, heartbeat and windowed RMS results, and checks each result transfer in order.
// Depends on wrms_pkg and the windowed_rms_level_meter_core RTL.
`timescale 1ns / 100ps

module windowed_rms_level_meter_core_tb;

  localparam logic [wrms_pkg::ADDR_BITS-1:0] WINDOW_LEN_ADDR =
    wrms_pkg::ADDR_BITS'(4 * wrms_pkg::REG_WINDOW_LEN);
  localparam int unsigned BAR_STEP = 1000;

  typedef struct packed {
    logic                             bar_red;
    logic                             bar_green;
    logic                             bar_blue;
    logic                             heartbeat;
    logic                             rms_valid;
    logic [wrms_pkg::SAMPLE_BITS-1:0] rms_counts;
    logic [wrms_pkg::MV_BITS-1:0]     rms_millivolts;
  } meter_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [wrms_pkg::ADDR_BITS-1:0]   paddr = '0;
  logic [wrms_pkg::DATA_BITS-1:0]   pwdata = '0;
  logic [wrms_pkg::DATA_BITS-1:0]   prdata;
  logic                             pready;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [wrms_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             bar_red;
  logic                             bar_green;
  logic                             bar_blue;
  logic                             heartbeat;
  logic                             rms_valid;
  logic [wrms_pkg::SAMPLE_BITS-1:0] rms_counts;
  logic [wrms_pkg::MV_BITS-1:0]     rms_millivolts;

  // Predictor state: mirror of the block's accumulator and register
  logic [wrms_pkg::SUM_BITS-1:0]    acc_sum;
  logic [wrms_pkg::WINDOW_BITS-1:0] acc_count;
  logic                             beat_level;
  logic [wrms_pkg::WINDOW_BITS-1:0] window_len_reg;

  meter_result_t expected_readings[$];
  int unsigned   mismatch_count = 0;

  // Idle knobs, percent chance of a sender gap / receiver stall
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;

  int unsigned sample_corners [10] = '{0, 999, 1000, 1999, 2000, 2999, 3000, 3999, 4000, 4095};

  windowed_rms_level_meter_core i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bar_red(bar_red),
    .bar_green(bar_green),
    .bar_blue(bar_blue),
    .heartbeat(heartbeat),
    .rms_valid(rms_valid),
    .rms_counts(rms_counts),
    .rms_millivolts(rms_millivolts)
  );

  always #4 clk = ~clk;

  // Bound the run in case the block hangs
  initial begin
    #60_000_000;
    $display("windowed_rms_level_meter_core verification failed");
    $finish;
  end

  // Advance the predictor by one sample and return the result it should give
  function automatic meter_result_t predict_meter(input logic [wrms_pkg::SAMPLE_BITS-1:0] s);
    meter_result_t r;
    logic [63:0]   len;
    logic [63:0]   mean;
    logic [63:0]   root;
    logic [63:0]   trial;
    int unsigned   level;
    r = '0;
    level = int'(s) / BAR_STEP;
    if (window_len_reg == 0) begin
      len = 1;
    end else if (window_len_reg > wrms_pkg::MAX_WINDOW) begin
      len = 64'(wrms_pkg::MAX_WINDOW);
    end else begin
      len = 64'(window_len_reg);
    end
    beat_level = ~beat_level;
    acc_sum = acc_sum + wrms_pkg::SUM_BITS'(64'(s) * 64'(s));
    acc_count = acc_count + 1'b1;
    if (64'(acc_count) >= len) begin
      mean = 64'(acc_sum) / len;
      root = 0;
      for (int b = 18; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean) root = trial;
      end
      r.rms_valid = 1'b1;
      r.rms_counts = root[wrms_pkg::SAMPLE_BITS-1:0];
      r.rms_millivolts = wrms_pkg::MV_BITS'((root * 64'(wrms_pkg::MV_SCALE))
                                            / 64'(wrms_pkg::FULL_SCALE));
      acc_sum = '0;
      acc_count = '0;
    end
    r.bar_red = (level >= 1);
    r.bar_green = (level >= 2);
    r.bar_blue = (level >= 3);
    r.heartbeat = beat_level;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver stalls: mostly short bursts, occasionally long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = ($urandom_range(11) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    meter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("bar_red", want.bar_red, bar_red);
        check_field("bar_green", want.bar_green, bar_green);
        check_field("bar_blue", want.bar_blue, bar_blue);
        check_field("heartbeat", want.heartbeat, heartbeat);
        check_field("rms_valid", want.rms_valid, rms_valid);
        check_field("rms_counts", want.rms_counts, rms_counts);
        check_field("rms_millivolts", want.rms_millivolts, rms_millivolts);
      end
    end
  end

  // Send one sample; valid stays high afterwards until the next gap or drain
  task automatic send_sample(input logic [wrms_pkg::SAMPLE_BITS-1:0] s);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(predict_meter(s));
  endtask

  // Hold the sender until every predicted result has been transferred
  task automatic wait_results_drained;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [wrms_pkg::DATA_BITS-1:0] data,
                            output logic [wrms_pkg::DATA_BITS-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= WINDOW_LEN_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_window_len;
    logic [wrms_pkg::DATA_BITS-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    check_field("window_len readback", window_len_reg, rdata[wrms_pkg::WINDOW_BITS-1:0]);
  endtask

  // Write window_len (block must be idle), then read it back
  task automatic write_window_len(input logic [wrms_pkg::DATA_BITS-1:0] data);
    logic [wrms_pkg::DATA_BITS-1:0] rdata;
    apb_access(1'b1, data, rdata);
    window_len_reg = data[wrms_pkg::WINDOW_BITS-1:0];
    check_window_len();
  endtask

  function automatic logic [wrms_pkg::SAMPLE_BITS-1:0] pick_sample;
    if ($urandom_range(3) == 0) begin
      return wrms_pkg::SAMPLE_BITS'(sample_corners[$urandom_range(9)]);
    end
    return wrms_pkg::SAMPLE_BITS'($urandom_range(4095));
  endfunction

  // Reset value: window_len reads 2400 and a partial window gives no RMS
  task automatic test_reset_window;
    check_window_len();
    gap_pct = 10;
    stall_pct = 10;
    repeat (200) send_sample(pick_sample());
    wait_results_drained();
  endtask

  // Bar thresholds, unit and zero window lengths, a three-sample window
  task automatic test_bar_and_short_windows;
    gap_pct = 0;
    stall_pct = 0;
    write_window_len(32'hFFFF_E001);
    foreach (sample_corners[i]) send_sample(wrms_pkg::SAMPLE_BITS'(sample_corners[i]));
    wait_results_drained();
    write_window_len(32'h0000_0000);
    send_sample(12'd4095);
    send_sample(12'd0);
    wait_results_drained();
    write_window_len(32'd3);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd1);
    wait_results_drained();
  endtask

  // Shorten the window while part of one has been collected
  task automatic test_window_shortening;
    gap_pct = 30;
    stall_pct = 30;
    write_window_len(32'd8);
    repeat (6) send_sample(pick_sample());
    wait_results_drained();
    write_window_len(32'd3);
    send_sample(pick_sample());
    wait_results_drained();
    write_window_len({19'($urandom), 13'd4096});
    repeat (5) send_sample(pick_sample());
    wait_results_drained();
    write_window_len(32'd2);
    send_sample(pick_sample());
    wait_results_drained();
  endtask

  // Oversized length clamps to the maximum window; a long full-scale run then closes
  // at unit length, so the root and millivolts exceed their field widths
  task automatic test_full_window;
    gap_pct = 0;
    stall_pct = 0;
    write_window_len({19'($urandom), 13'h1FFF});
    repeat (120) send_sample(12'd4095);
    wait_results_drained();
    write_window_len(32'd1);
    send_sample(12'd4095);
    wait_results_drained();
  endtask

  // Random windows of mostly small lengths, each with its own idle pattern
  task automatic test_random_windows;
    int unsigned sent;
    int unsigned len;
    int unsigned n;
    sent = 0;
    while (sent < 400) begin
      wait_results_drained();
      case ($urandom_range(9))
        0: len = 0;
        1, 2: len = $urandom_range(13, 64);
        default: len = $urandom_range(1, 12);
      endcase
      write_window_len({19'($urandom), 13'(len)});
      case ($urandom_range(2))
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 20;
          stall_pct = 20;
        end
        default: begin
          gap_pct = 60;
          stall_pct = 50;
        end
      endcase
      n = $urandom_range(1, 3 * ((len == 0) ? 1 : len) + 2);
      repeat (n) begin
        send_sample(pick_sample());
        sent++;
      end
    end
    wait_results_drained();
  endtask

  initial begin
    acc_sum = '0;
    acc_count = '0;
    beat_level = 1'b0;
    window_len_reg = wrms_pkg::WINDOW_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_bar_and_short_windows();
    test_window_shortening();
    test_full_window();
    test_random_windows();
    // Let any stray result show up before the verdict
    stall_pct = 0;
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("windowed_rms_level_meter_core verification clean");
    end else begin
      $display("windowed_rms_level_meter_core verification failed");
    end
    $finish;
  end

endmodule
